@@ src/lfu_pkg.sv @@
package lfu_pkg;

    localparam int KEY_W = 32;
    localparam int CNT_W = 32;
    localparam int CFG_W = 7;
    localparam logic [KEY_W-1:0] MISS_VALUE = '1;
    localparam logic [CNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [CFG_W-1:0] CAP_RESET  = 7'd64;

    // Fixed-width part of the scan beat that ripples down the row of cells.
    typedef struct packed {
        logic             found;
        logic [KEY_W-1:0] fdata;
        logic             free_found;
        logic             vic_valid;
        logic [CNT_W-1:0] vic_cnt;
        logic [KEY_W-1:0] vic_key;
    } t_scan;

    // Update broadcast to every cell for one cycle at the end of a request's scan.
    typedef struct packed {
        logic             load;
        logic             wr_data;
        logic             age_all;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] data;
    } t_cmd;

endpackage

@@ src/lfu_cell.sv @@
module lfu_cell #(
    parameter int N   = 64,
    parameter int IDX = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [lfu_pkg::KEY_W-1:0]  i_key,
    input  lfu_pkg::t_scan             i_scan,
    input  logic [((N>1)?$clog2(N):1)-1:0] i_fidx,
    input  logic [((N>1)?$clog2(N):1)-1:0] i_frank,
    input  logic [((N>1)?$clog2(N):1)-1:0] i_free_idx,
    input  logic [((N>1)?$clog2(N):1)-1:0] i_vic_idx,
    input  logic [((N>1)?$clog2(N):1)-1:0] i_vic_rank,
    output lfu_pkg::t_scan             o_scan,
    output logic [((N>1)?$clog2(N):1)-1:0] o_fidx,
    output logic [((N>1)?$clog2(N):1)-1:0] o_frank,
    output logic [((N>1)?$clog2(N):1)-1:0] o_free_idx,
    output logic [((N>1)?$clog2(N):1)-1:0] o_vic_idx,
    output logic [((N>1)?$clog2(N):1)-1:0] o_vic_rank,
    input  logic                       i_cmd_en,
    input  lfu_pkg::t_cmd              i_cmd,
    input  logic [((N>1)?$clog2(N):1)-1:0] i_cmd_idx,
    input  logic [((N>1)?$clog2(N):1)-1:0] i_cmd_rank
);
    import lfu_pkg::*;

    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam logic [IW-1:0] MY = IW'(IDX);

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_data;
    logic [CNT_W-1:0] r_cnt;
    logic [IW-1:0]    r_rank;

    t_scan         r_scan, n_scan;
    logic [IW-1:0] r_fidx, n_fidx, r_frank, n_frank, r_free_idx, n_free_idx;
    logic [IW-1:0] r_vic_idx, n_vic_idx, r_vic_rank, n_vic_rank;
    logic          better;

    always_comb begin
        n_scan     = i_scan;
        n_fidx     = i_fidx;
        n_frank    = i_frank;
        n_free_idx = i_free_idx;
        n_vic_idx  = i_vic_idx;
        n_vic_rank = i_vic_rank;
        if (!i_scan.found && r_valid && (r_key == i_key)) begin
            n_scan.found = 1'b1;
            n_scan.fdata = r_data;
            n_fidx       = MY;
            n_frank      = r_rank;
        end
        if (!i_scan.free_found && !r_valid) begin
            n_scan.free_found = 1'b1;
            n_free_idx        = MY;
        end
        better = r_valid && (!i_scan.vic_valid || (r_cnt < i_scan.vic_cnt) ||
                 ((r_cnt == i_scan.vic_cnt) && (r_rank > i_vic_rank)));
        if (better) begin
            n_scan.vic_valid = 1'b1;
            n_scan.vic_cnt   = r_cnt;
            n_scan.vic_key   = r_key;
            n_vic_idx        = MY;
            n_vic_rank       = r_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_fidx     <= n_fidx;
        r_frank    <= n_frank;
        r_free_idx <= n_free_idx;
        r_vic_idx  <= n_vic_idx;
        r_vic_rank <= n_vic_rank;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd_en && (i_cmd_idx == MY) && i_cmd.load) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_en) begin
            if (i_cmd_idx == MY) begin
                r_rank <= '0;
                if (i_cmd.load) begin
                    r_key  <= i_cmd.key;
                    r_data <= i_cmd.data;
                    r_cnt  <= CNT_W'(1);
                end else begin
                    if (r_cnt != COUNT_MAX) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    if (i_cmd.wr_data) begin
                        r_data <= i_cmd.data;
                    end
                end
            end else if (r_valid && (i_cmd.age_all || (r_rank < i_cmd_rank))) begin
                r_rank <= r_rank + IW'(1);
            end
        end
    end

    assign o_scan     = r_scan;
    assign o_fidx     = r_fidx;
    assign o_frank    = r_frank;
    assign o_free_idx = r_free_idx;
    assign o_vic_idx  = r_vic_idx;
    assign o_vic_rank = r_vic_rank;

endmodule

@@ src/lfu_cache_lru_tiebreak_top.sv @@
// LFU key-value cache with LRU tie-break, built as a row of MAX_ENTRIES
// identical cells. Each cell holds one entry (valid, key, value, use count,
// recency rank). A request is taken one at a time: after a beat is accepted,
// a scan beat ripples down the row, one cell per cycle, collecting the key
// match, the first free slot and the eviction victim (lowest count, oldest
// among equal counts). In the cycle in which the beat leaves the last cell,
// the update is broadcast to all cells at once and the result is written
// to a pending register; it moves on to the output register as soon as
// that register is free. A finished result may wait in the output register
// while the next request is scanned. The capacity register may be written
// only while the block is idle; values above MAX_ENTRIES act as MAX_ENTRIES,
// and zero makes every put a no-op.
module lfu_cache_lru_tiebreak_top #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_req_type,
    input  logic signed [31:0]        i_lookup_key,
    input  logic signed [31:0]        i_write_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_hit,
    output logic signed [31:0]        o_read_value,
    output logic                      o_evicted,
    output logic signed [31:0]        o_evicted_key
);
    import lfu_pkg::*;

    localparam int N  = MAX_ENTRIES;
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int OW = $clog2(N + 1);
    localparam int CW = $clog2(N + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]       r_state;
    logic [CW-1:0]    r_cnt;
    logic [CFG_W-1:0] r_cap;
    logic [OW-1:0]    r_occ;
    logic             r_put;
    logic [KEY_W-1:0] r_key, r_wval;

    // Pending result and output register.
    logic             r_p_hit, r_p_ev;
    logic [KEY_W-1:0] r_p_rv, r_p_ek;
    logic             r_o_valid, r_o_hit, r_o_ev;
    logic [KEY_W-1:0] r_o_rv, r_o_ek;

    t_scan         scan   [N+1];
    logic [IW-1:0] fidx   [N+1];
    logic [IW-1:0] frank  [N+1];
    logic [IW-1:0] fridx  [N+1];
    logic [IW-1:0] vidx   [N+1];
    logic [IW-1:0] vrank  [N+1];

    logic          cmd_en;
    t_cmd          cmd;
    logic [IW-1:0] cmd_idx, cmd_rank;
    logic          scan_done, cap_zero, occ_lt_cap, fill_free;
    logic [31:0]   cap_eff;
    logic          n_hit, n_ev;
    logic [KEY_W-1:0] n_rv, n_ek;
    logic          accept, out_free;

    assign scan[0]  = '0;
    assign fidx[0]  = '0;
    assign frank[0] = '0;
    assign fridx[0] = '0;
    assign vidx[0]  = '0;
    assign vrank[0] = '0;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            lfu_cell #(.N(N), .IDX(g)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_key      (r_key),
                .i_scan     (scan[g]),
                .i_fidx     (fidx[g]),
                .i_frank    (frank[g]),
                .i_free_idx (fridx[g]),
                .i_vic_idx  (vidx[g]),
                .i_vic_rank (vrank[g]),
                .o_scan     (scan[g+1]),
                .o_fidx     (fidx[g+1]),
                .o_frank    (frank[g+1]),
                .o_free_idx (fridx[g+1]),
                .o_vic_idx  (vidx[g+1]),
                .o_vic_rank (vrank[g+1]),
                .i_cmd_en   (cmd_en),
                .i_cmd      (cmd),
                .i_cmd_idx  (cmd_idx),
                .i_cmd_rank (cmd_rank)
            );
        end
    endgenerate

    assign accept    = i_valid && (r_state == ST_IDLE);
    assign o_stall   = (r_state != ST_IDLE);
    assign out_free  = !r_o_valid || !i_stall;
    assign scan_done = (r_state == ST_SCAN) && (r_cnt == CW'(N));

    // Effective capacity: register value clamped to the number of cells.
    assign cap_eff    = ({25'd0, r_cap} > 32'(N)) ? 32'(N) : {25'd0, r_cap};
    assign cap_zero   = (cap_eff == 32'd0);
    assign occ_lt_cap = (32'(r_occ) < cap_eff);
    assign fill_free  = r_put && !cap_zero && !scan[N].found && occ_lt_cap;

    // Decide the update and the result from the beat leaving the last cell.
    always_comb begin
        cmd_en      = 1'b0;
        cmd         = '0;
        cmd.key     = r_key;
        cmd.data    = r_wval;
        cmd_idx     = fidx[N];
        cmd_rank    = frank[N];
        n_hit       = scan[N].found;
        n_rv        = MISS_VALUE;
        n_ev        = 1'b0;
        n_ek        = '0;
        if (scan[N].found) begin
            if (!r_put) begin
                n_rv   = scan[N].fdata;
                cmd_en = scan_done;
            end else if (!cap_zero) begin
                cmd.wr_data = 1'b1;
                cmd_en      = scan_done;
            end
        end else if (r_put && !cap_zero) begin
            cmd.load = 1'b1;
            cmd_en   = scan_done;
            if (occ_lt_cap) begin
                cmd.age_all = 1'b1;
                cmd_idx     = fridx[N];
            end else begin
                // Eviction: entries younger than the victim age by one; the
                // older ones close the gap and age again, so they stay put.
                cmd_idx  = vidx[N];
                cmd_rank = vrank[N];
                n_ev     = 1'b1;
                n_ek     = scan[N].vic_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_cap     <= CAP_RESET;
            r_occ     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if ((r_state == ST_OUT) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_SCAN;
                        r_cnt   <= '0;
                    end
                end
                ST_SCAN: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (scan_done) begin
                        r_state <= ST_OUT;
                        if (fill_free) begin
                            r_occ <= r_occ + OW'(1);
                        end
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_put  <= i_req_type;
            r_key  <= i_lookup_key;
            r_wval <= i_write_value;
        end
        if (scan_done) begin
            r_p_hit <= n_hit;
            r_p_rv  <= n_rv;
            r_p_ev  <= n_ev;
            r_p_ek  <= n_ek;
        end
        if ((r_state == ST_OUT) && out_free) begin
            r_o_hit <= r_p_hit;
            r_o_rv  <= r_p_rv;
            r_o_ev  <= r_p_ev;
            r_o_ek  <= r_p_ek;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_hit         = r_o_hit;
    assign o_read_value  = r_o_rv;
    assign o_evicted     = r_o_ev;
    assign o_evicted_key = r_o_ek;

endmodule
